// ----- hdl/ohl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered handle list package
// Sizes, operation and status codes, and the command word that the top level
// broadcasts along the row of entry cells.
// ----------------------------------------------------------------------------
package ohl_pkg;

	localparam int DEPTH    = 16;
	localparam int HANDLE_W = 16;
	localparam int IDX_W    = 4;
	localparam int CNT_W    = 5;
	localparam int KIND_W   = 3;
	localparam int STAT_W   = 2;

	localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_BADIDX = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic                en;
		logic [KIND_W-1:0]   kind;
		logic [IDX_W-1:0]    pos;
		logic [CNT_W-1:0]    cnt;
		logic [HANDLE_W-1:0] handle;
	} ohl_cmd_t;

endpackage

// ----- hdl/ohl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered handle list channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface ohl_req_if;
	logic                         valid;
	logic                         ready;
	logic [ohl_pkg::KIND_W-1:0]   kind;
	logic [ohl_pkg::IDX_W-1:0]    position;
	logic [ohl_pkg::HANDLE_W-1:0] handle;

	modport source (output valid, kind, position, handle, input ready);
	modport sink   (input valid, kind, position, handle, output ready);
endinterface

interface ohl_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ohl_pkg::HANDLE_W-1:0] read_handle;
	logic [ohl_pkg::IDX_W-1:0]    match_index;
	logic                         match_found;
	logic [ohl_pkg::STAT_W-1:0]   status;
	logic [ohl_pkg::CNT_W-1:0]    entry_count;

	modport source (output valid, read_handle, match_index, match_found, status,
		entry_count, input ready);
	modport sink   (input valid, read_handle, match_index, match_found, status,
		entry_count, output ready);
endinterface

// ----- hdl/ohl_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered handle list cell
// Holds one entry; loads the new handle, takes a neighbour's entry on a
// shift, or clears, as the broadcast command decides for its own index.
// ----------------------------------------------------------------------------
module ohl_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ohl_pkg::IDX_W-1:0]    idx,
	input  ohl_pkg::ohl_cmd_t            cmd,
	input  logic [ohl_pkg::HANDLE_W-1:0] left,
	input  logic [ohl_pkg::HANDLE_W-1:0] right,
	output logic [ohl_pkg::HANDLE_W-1:0] entry,
	output logic                         hit
);
	import ohl_pkg::*;

	logic [HANDLE_W-1:0] entry_q;
	logic [HANDLE_W-1:0] next_d;
	logic [CNT_W-1:0]    idx_c;
	logic [CNT_W-1:0]    idx_p1;
	logic [CNT_W-1:0]    pos_c;

	assign idx_c  = {1'b0, idx};
	assign idx_p1 = idx_c + CNT_W'(1);
	assign pos_c  = {1'b0, cmd.pos};

	always_comb begin
		next_d = entry_q;
		case (cmd.kind)
			KIND_APPEND: begin
				if (idx_c == cmd.cnt) next_d = cmd.handle;
			end
			KIND_WRITE: begin
				if (idx_c == pos_c) next_d = cmd.handle;
			end
			KIND_INSERT: begin
				if (idx_c == pos_c) begin
					next_d = cmd.handle;
				end else if (idx_c > pos_c && idx_c <= cmd.cnt) begin
					next_d = left;
				end
			end
			KIND_REMOVE: begin
				// The freed last slot is cleared; slots from the gap up take the entry above.
				if (idx_p1 == cmd.cnt) begin
					next_d = '0;
				end else if (idx_c >= pos_c && idx_p1 < cmd.cnt) begin
					next_d = right;
				end
			end
			default: next_d = entry_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (cmd.en) begin
			entry_q <= next_d;
		end
	end

	assign entry = entry_q;
	assign hit   = (entry_q == cmd.handle);

endmodule

// ----- hdl/ordered_handle_list.sv -----
`timescale 1ns / 1ps
// A response word is registered and shown in the cycle after its request word is accepted.
// One word per cycle while rsp is ready; every operation is one pass of the cell row.
// The output register lets a new word enter while the previous response is being taken.
// Reset clears the count and every entry cell to zero, and empties the output register.
// ----------------------------------------------------------------------------
// Ordered handle list
// A row of entry cells with append, read, write, insert, remove and search.
// ----------------------------------------------------------------------------
module ordered_handle_list (
	input  logic      clk,
	input  logic      arst_n,
	ohl_req_if.sink   req,
	ohl_rsp_if.source rsp
);
	import ohl_pkg::*;

	logic [HANDLE_W-1:0] ent [DEPTH];
	logic [DEPTH-1:0]    hits;
	logic [CNT_W-1:0]    cnt_q;
	logic                accept;
	logic                full;
	logic                pos_lt_cnt;
	logic [CNT_W-1:0]    pos_c;
	logic [STAT_W-1:0]   status_d;
	logic [CNT_W-1:0]    cnt_d;
	logic [HANDLE_W-1:0] rd_d;
	logic [IDX_W-1:0]    midx_d;
	logic                mfound_d;
	ohl_cmd_t            cmd;

	logic                valid_q;
	logic [HANDLE_W-1:0] rd_q;
	logic [IDX_W-1:0]    midx_q;
	logic                mfound_q;
	logic [STAT_W-1:0]   status_q;
	logic [CNT_W-1:0]    cnt_out_q;

	assign req.ready  = !valid_q || rsp.ready;
	assign accept     = req.valid && req.ready;
	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign pos_c      = {1'b0, req.position};
	assign pos_lt_cnt = (pos_c < cnt_q);

	always_comb begin
		status_d = ST_OK;
		cnt_d    = cnt_q;
		rd_d     = '0;
		case (req.kind)
			KIND_APPEND: begin
				if (full) status_d = ST_FULL;
				else cnt_d = cnt_q + CNT_W'(1);
			end
			KIND_READ: begin
				if (pos_lt_cnt) begin
					rd_d = ent[req.position];
				end else begin
					rd_d     = ent[0];
					status_d = ST_BADIDX;
				end
			end
			KIND_WRITE: begin
				if (!pos_lt_cnt) status_d = ST_BADIDX;
			end
			KIND_INSERT: begin
				if (full) status_d = ST_FULL;
				else if (pos_c > cnt_q) status_d = ST_BADIDX;
				else cnt_d = cnt_q + CNT_W'(1);
			end
			KIND_REMOVE: begin
				if (!pos_lt_cnt) status_d = ST_BADIDX;
				else cnt_d = cnt_q - CNT_W'(1);
			end
			default: status_d = ST_OK;
		endcase
	end

	// First matching entry below the count wins.
	always_comb begin
		midx_d   = '0;
		mfound_d = 1'b0;
		if (req.kind == KIND_SEARCH) begin
			for (int i = DEPTH - 1; i >= 0; i--) begin
				if (hits[i] && (CNT_W'(i) < cnt_q)) begin
					midx_d   = IDX_W'(i);
					mfound_d = 1'b1;
				end
			end
		end
	end

	always_comb begin
		cmd.en     = accept && (status_d == ST_OK);
		cmd.kind   = req.kind;
		cmd.pos    = req.position;
		cmd.cnt    = cnt_q;
		cmd.handle = req.handle;
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [HANDLE_W-1:0] left_w;
		logic [HANDLE_W-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = ent[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = ent[g+1];
		end
		ohl_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (IDX_W'(g)),
			.cmd    (cmd),
			.left   (left_w),
			.right  (right_w),
			.entry  (ent[g]),
			.hit    (hits[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q   <= cnt_d;
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q      <= rd_d;
			midx_q    <= midx_d;
			mfound_q  <= mfound_d;
			status_q  <= status_d;
			cnt_out_q <= cnt_d;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.read_handle = rd_q;
	assign rsp.match_index = midx_q;
	assign rsp.match_found = mfound_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = cnt_out_q;

endmodule
